/* design/dcfs_pkg.sv */
// Package for the byte-memory DMA engine: sizes, request kinds, microcode
// word layout, the control ROM and the dispatch table.
// Depends on nothing; imported by dma_copy_fill_search and its testbench.
`timescale 1ns / 1ps

package dcfs_pkg;

  localparam int unsigned MEM_DEPTH = 65536;
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned CW = 25;
  localparam int unsigned UPC_W = 4;

  localparam logic [31:0] LEN_CAP = 32'h0100_0000;
  localparam logic [31:0] NOT_FOUND = 32'hFFFF_FFFF;
  localparam logic [7:0] OUTSIDE_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    REQ_READ = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_COPY = 3'd2,
    REQ_FILL = 3'd3,
    REQ_RUN_FWD = 3'd4,
    REQ_FIND = 3'd5,
    REQ_RUN_BACK = 3'd6
  } req_kind_t;

  typedef enum logic [2:0] {
    C_ALWAYS = 3'd0,
    C_ACCEPT = 3'd1,
    C_CLR_DONE = 3'd2,
    C_DISPATCH = 3'd3,
    C_LAST = 3'd4,
    C_SEARCH_END = 3'd5,
    C_OUT_FREE = 3'd6
  } cond_t;

  typedef enum logic [1:0] {
    A_SRC = 2'd0,
    A_DST = 2'd1,
    A_CNT = 2'd2
  } asel_t;

  typedef enum logic [1:0] {
    W_NONE = 2'd0,
    W_ZERO = 2'd1,
    W_VAL = 2'd2,
    W_RDATA = 2'd3
  } wsel_t;

  localparam logic [UPC_W-1:0] U_CLEAR = 4'd0;
  localparam logic [UPC_W-1:0] U_IDLE = 4'd1;
  localparam logic [UPC_W-1:0] U_DECODE = 4'd2;
  localparam logic [UPC_W-1:0] U_RD_DONE = 4'd3;
  localparam logic [UPC_W-1:0] U_WRITE = 4'd4;
  localparam logic [UPC_W-1:0] U_FILL = 4'd5;
  localparam logic [UPC_W-1:0] U_CP_RD = 4'd6;
  localparam logic [UPC_W-1:0] U_CP_WR = 4'd7;
  localparam logic [UPC_W-1:0] U_SR_RD = 4'd8;
  localparam logic [UPC_W-1:0] U_SR_CMP = 4'd9;
  localparam logic [UPC_W-1:0] U_FINISH = 4'd10;

  typedef struct packed {
    logic [UPC_W-1:0] t_true;
    logic [UPC_W-1:0] t_false;
    cond_t cond;
    asel_t asel;
    wsel_t wsel;
    logic ld_item;
    logic setup;
    logic step_s;
    logic step_d;
    logic cnt_inc;
    logic res_rd;
    logic srch_eval;
    logic push;
  } ucode_t;

  function automatic ucode_t ucode(input logic [UPC_W-1:0] pc);
    ucode_t u;
    u = '{t_true: U_IDLE, t_false: U_IDLE, cond: C_ALWAYS, asel: A_SRC,
          wsel: W_NONE, default: 1'b0};
    case (pc)
      U_CLEAR: begin
        u.asel = A_CNT;
        u.wsel = W_ZERO;
        u.cnt_inc = 1'b1;
        u.cond = C_CLR_DONE;
        u.t_true = U_IDLE;
        u.t_false = U_CLEAR;
      end
      U_IDLE: begin
        u.ld_item = 1'b1;
        u.cond = C_ACCEPT;
        u.t_true = U_DECODE;
        u.t_false = U_IDLE;
      end
      U_DECODE: begin
        u.setup = 1'b1;
        u.cond = C_DISPATCH;
      end
      U_RD_DONE: begin
        u.res_rd = 1'b1;
        u.t_true = U_FINISH;
      end
      U_WRITE: begin
        u.asel = A_SRC;
        u.wsel = W_VAL;
        u.t_true = U_FINISH;
      end
      U_FILL: begin
        u.asel = A_DST;
        u.wsel = W_VAL;
        u.step_d = 1'b1;
        u.cnt_inc = 1'b1;
        u.cond = C_LAST;
        u.t_true = U_FINISH;
        u.t_false = U_FILL;
      end
      U_CP_RD: begin
        u.t_true = U_CP_WR;
      end
      U_CP_WR: begin
        u.asel = A_DST;
        u.wsel = W_RDATA;
        u.step_s = 1'b1;
        u.step_d = 1'b1;
        u.cnt_inc = 1'b1;
        u.cond = C_LAST;
        u.t_true = U_FINISH;
        u.t_false = U_CP_RD;
      end
      U_SR_RD: begin
        u.t_true = U_SR_CMP;
      end
      U_SR_CMP: begin
        u.srch_eval = 1'b1;
        u.step_s = 1'b1;
        u.cnt_inc = 1'b1;
        u.cond = C_SEARCH_END;
        u.t_true = U_FINISH;
        u.t_false = U_SR_RD;
      end
      U_FINISH: begin
        u.push = 1'b1;
        u.cond = C_OUT_FREE;
        u.t_true = U_IDLE;
        u.t_false = U_FINISH;
      end
      default: begin
        u.t_true = U_IDLE;
      end
    endcase
    return u;
  endfunction

  function automatic logic [UPC_W-1:0] dispatch(input req_kind_t kind,
                                                input logic zero_len);
    logic [UPC_W-1:0] pc;
    pc = U_FINISH;
    case (kind)
      REQ_READ: pc = U_RD_DONE;
      REQ_WRITE: pc = U_WRITE;
      REQ_COPY: pc = zero_len ? U_FINISH : U_CP_RD;
      REQ_FILL: pc = zero_len ? U_FINISH : U_FILL;
      REQ_RUN_FWD, REQ_FIND, REQ_RUN_BACK: pc = zero_len ? U_FINISH : U_SR_RD;
      default: pc = U_FINISH;
    endcase
    return pc;
  endfunction

endpackage

/* design/dma_copy_fill_search.sv */
// Byte-memory DMA engine with copy, fill and byte search commands.
// Microcoded sequencer over a byte RAM; control ROM and types from dcfs_pkg.
//
// Usage: one request per s_axis transfer, one result per m_axis transfer.
// s_axis_tuser carries the request kind; s_axis_tdata carries the addresses,
// the length and the byte value. m_axis_tdata returns the byte read, the
// search count or index, or the length echoed.
// After rst the RAM is cleared one byte per cycle, all MEM_DEPTH bytes
// (65536), with s_axis_tready low; then the engine goes idle.
// A request passes through decode to its work steps and then to the finish
// step; zero length and unknown kinds go straight to finish. A search stops
// at its first hit or after n bytes (n = length capped at 2^24).
// The RAM has one write and one read port; copy and search spend a read
// step and a compare/write step per byte, fill writes a byte every cycle.
// One request is in work at a time; s_axis_tready is high only when the
// sequencer is idle. A finished result sits in the output register while
// the next request is taken; if m_axis_tready stays low the sequencer holds
// at its final step until the output register frees.
`timescale 1ns / 1ps

module dma_copy_fill_search
  import dcfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_addr[31:0], dst_addr[63:32], length[95:64], byte_value[103:96]
  input  logic [103:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[31:0]
  output logic [31:0]  m_axis_tdata
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ucode_t uw;

  req_kind_t kind;
  logic [31:0] src;
  logic [31:0] dst;
  logic [7:0] val;
  logic [CW-1:0] n;
  logic [CW-1:0] cnt;
  logic [31:0] ptr_s;
  logic [31:0] ptr_d;
  logic back;
  logic [31:0] res;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata_q;
  logic rd_inr_q;
  logic [7:0] rbyte;

  logic accept;
  logic out_free;
  logic take;
  logic last;
  logic hit;
  logic copy_back;
  logic [31:0] diff;
  logic [31:0] len_in;
  logic [31:0] wr_addr;
  logic [7:0] wr_data;
  logic wr_en;

  assign uw = ucode(upc);
  assign s_axis_tready = (upc == U_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign len_in = s_axis_tdata[95:64];

  assign rbyte = rd_inr_q ? rdata_q : OUTSIDE_BYTE;
  assign last = ((cnt + CW'(1)) == n);
  assign hit = (kind == REQ_FIND) ? (rbyte == val) : (rbyte != val);

  // copy runs downward when the destination overlaps the source ahead of it
  assign diff = dst - src;
  assign copy_back = (kind == REQ_COPY) && (diff != 32'd0) && (diff < 32'(n));

  always_comb begin
    case (uw.cond)
      C_ALWAYS: take = 1'b1;
      C_ACCEPT: take = accept;
      C_CLR_DONE: take = (cnt == CW'(MEM_DEPTH - 1));
      C_LAST: take = last;
      C_SEARCH_END: take = hit || last;
      C_OUT_FREE: take = out_free;
      default: take = 1'b1;
    endcase
    if (uw.cond == C_DISPATCH) begin
      upc_next = dispatch(kind, n == '0);
    end else begin
      upc_next = take ? uw.t_true : uw.t_false;
    end
  end

  always_comb begin
    case (uw.asel)
      A_SRC: wr_addr = ptr_s;
      A_DST: wr_addr = ptr_d;
      A_CNT: wr_addr = 32'(cnt);
      default: wr_addr = ptr_d;
    endcase
    case (uw.wsel)
      W_ZERO: wr_data = 8'h00;
      W_VAL: wr_data = val;
      W_RDATA: wr_data = rbyte;
      default: wr_data = 8'h00;
    endcase
    wr_en = (uw.wsel != W_NONE) && (wr_addr < 32'(MEM_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_CLEAR;
      cnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (uw.ld_item && accept) begin
        cnt <= '0;
      end else if (uw.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end
      if (uw.push && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw.ld_item && accept) begin
      kind <= req_kind_t'(s_axis_tuser);
      src <= s_axis_tdata[31:0];
      dst <= s_axis_tdata[63:32];
      val <= s_axis_tdata[103:96];
      n <= (len_in > LEN_CAP) ? LEN_CAP[CW-1:0] : len_in[CW-1:0];
      ptr_s <= s_axis_tdata[31:0];
      ptr_d <= s_axis_tdata[63:32];
      res <= len_in;
    end else begin
      if (uw.setup) begin
        back <= copy_back || (kind == REQ_RUN_BACK);
        if (copy_back) begin
          ptr_s <= src + 32'(n) - 32'd1;
          ptr_d <= dst + 32'(n) - 32'd1;
        end
      end
      if (uw.step_s) begin
        ptr_s <= back ? ptr_s - 32'd1 : ptr_s + 32'd1;
      end
      if (uw.step_d) begin
        ptr_d <= back ? ptr_d - 32'd1 : ptr_d + 32'd1;
      end
      if (uw.res_rd) begin
        res <= 32'(rbyte);
      end
      if (uw.srch_eval) begin
        if (hit) begin
          res <= 32'(cnt);
        end else if (last) begin
          res <= (kind == REQ_FIND) ? NOT_FOUND : 32'(n);
        end
      end
    end
    if (uw.push && out_free) begin
      m_axis_tdata <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    rdata_q <= mem[ptr_s[AW-1:0]];
    rd_inr_q <= (ptr_s < 32'(MEM_DEPTH));
  end

`ifndef SYNTH
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    accept |=> (upc == U_DECODE))
    else $error("request transfer not followed by decode step");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (upc == U_FILL || upc == U_CP_WR || upc == U_SR_CMP) |-> (cnt < n))
    else $error("byte counter ran past the command length");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(upc) == U_FINISH))
    else $error("result presented outside the finish step");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (upc == U_CLEAR) |-> (!m_axis_tvalid && !s_axis_tready))
    else $error("traffic during the RAM clearing pass");
`endif

endmodule

/* tb/dma_copy_fill_search_tb.sv */
// Testbench for dma_copy_fill_search: directed and random requests, checked
// against a byte-accurate shadow of the RAM kept inside the bench.
// Depends on dcfs_pkg and the dma_copy_fill_search RTL.
`timescale 1ns / 1ps

module dma_copy_fill_search_tb;
  import dcfs_pkg::*;

  localparam logic [2:0] REQ_UNKNOWN = 3'd7;
  localparam int unsigned WORK_MAX = 1024;
  // clear pass plus 1849 requests with walks bounded by WORK_MAX and long gaps, x5
  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [31:0] len;
    logic [31:0] dst;
    logic [31:0] src;
  } dma_req_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // src_addr[31:0], dst_addr[63:32], length[95:64], byte_value[103:96]
  logic [103:0] s_axis_tdata = '0;
  // req_type[2:0]
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // result_value[31:0]
  logic [31:0]  m_axis_tdata;

  logic [7:0]   shadow_mem [MEM_DEPTH];
  logic [31:0]  owed_results [$];
  logic [31:0]  want_value;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  sink_hold = 0;
  bit           src_gaps_on = 1'b1;
  bit           sink_gaps_on = 1'b1;

  dma_copy_fill_search dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** dma_copy_fill_search: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] mem_byte(input logic [31:0] a);
    logic [7:0] b;
    if (a < MEM_DEPTH) b = shadow_mem[a[AW-1:0]];
    else b = OUTSIDE_BYTE;
    return b;
  endfunction

  function automatic void store_byte(input logic [31:0] a, input logic [7:0] b);
    if (a < MEM_DEPTH) shadow_mem[a[AW-1:0]] = b;
  endfunction

  // true while the scan of a search request continues past step i
  function automatic bit keeps_going(input dma_req_t r, input logic [31:0] i);
    bit go;
    case (r.kind)
      REQ_RUN_FWD:  go = mem_byte(r.src + i) == r.value;
      REQ_FIND:     go = mem_byte(r.src + i) != r.value;
      REQ_RUN_BACK: go = mem_byte(r.src - i) == r.value;
      default:      go = 1'b0;
    endcase
    return go;
  endfunction

  // updates the shadow RAM and returns the result_value owed for r
  function automatic logic [31:0] apply_request(input dma_req_t r);
    logic [31:0] n;
    logic [31:0] i;
    logic [31:0] res;
    logic [7:0]  staged [$];
    res = r.len;
    n = (r.len > LEN_CAP) ? LEN_CAP : r.len;
    if (r.kind == REQ_READ) begin
      res = {24'd0, mem_byte(r.src)};
    end else if (r.kind == REQ_WRITE) begin
      store_byte(r.src, r.value);
    end else if (n != 0) begin
      case (r.kind)
        REQ_COPY: begin
          for (i = 0; i < n; i++) staged.push_back(mem_byte(r.src + i));
          for (i = 0; i < n; i++) store_byte(r.dst + i, staged[i]);
        end
        REQ_FILL: begin
          for (i = 0; i < n; i++) store_byte(r.dst + i, r.value);
        end
        REQ_RUN_FWD, REQ_FIND, REQ_RUN_BACK: begin
          i = 0;
          while (i < n && keeps_going(r, i)) i++;
          res = (r.kind == REQ_FIND && i >= n) ? NOT_FOUND : i;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  function automatic dma_req_t mk_req(input logic [2:0] kind, input logic [31:0] src,
                                      input logic [31:0] dst, input logic [31:0] len,
                                      input logic [7:0] value);
    dma_req_t r;
    r.kind = kind;
    r.src = src;
    r.dst = dst;
    r.len = len;
    r.value = value;
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit on);
    int unsigned p;
    int unsigned g;
    p = $urandom_range(0, 99);
    if (!on || p < 55) g = 0;
    else if (p < 90) g = $urandom_range(1, 3);
    else if (p < 98) g = $urandom_range(4, 12);
    else g = $urandom_range(20, 80);
    return g;
  endfunction

  function automatic logic [31:0] pick_addr();
    int unsigned p;
    logic [31:0] a;
    p = $urandom_range(0, 99);
    if (p < 60) a = $urandom_range(0, 2047);
    else if (p < 70) a = $urandom_range(0, 15);
    else if (p < 80) a = MEM_DEPTH - 40 + $urandom_range(0, 80);
    else if (p < 90) a = 32'hFFFF_FFC0 + $urandom_range(0, 63);
    else a = $urandom;
    return a;
  endfunction

  function automatic dma_req_t rand_request();
    dma_req_t r;
    int unsigned p;
    logic [31:0] n;
    logic [31:0] i;
    p = $urandom_range(0, 99);
    if (p < 14) r.kind = REQ_READ;
    else if (p < 28) r.kind = REQ_WRITE;
    else if (p < 40) r.kind = REQ_COPY;
    else if (p < 52) r.kind = REQ_FILL;
    else if (p < 66) r.kind = REQ_RUN_FWD;
    else if (p < 80) r.kind = REQ_FIND;
    else if (p < 96) r.kind = REQ_RUN_BACK;
    else r.kind = REQ_UNKNOWN;
    r.src = pick_addr();
    if ($urandom_range(0, 3) == 0) r.dst = r.src + $urandom_range(0, 16) - 8;
    else r.dst = pick_addr();
    p = $urandom_range(0, 99);
    if (p < 30) r.value = 8'h00;
    else if (p < 45) r.value = 8'hFF;
    else if (p < 70) r.value = 8'($urandom_range(1, 4));
    else r.value = 8'($urandom);
    p = $urandom_range(0, 99);
    if (r.kind == REQ_READ || r.kind == REQ_WRITE) r.len = $urandom;
    else if (p < 50) r.len = $urandom_range(0, 24);
    else if (p < 75) r.len = $urandom_range(25, 300);
    else if (p < 85) r.len = $urandom_range(301, WORK_MAX);
    else begin
      case ($urandom_range(0, 3))
        0: r.len = $urandom;
        1: r.len = LEN_CAP;
        2: r.len = LEN_CAP + 1;
        default: r.len = 32'hFFFF_FFFF;
      endcase
    end
    // keep the engine's walk short: bytes written, or bytes examined by a search
    n = (r.len > LEN_CAP) ? LEN_CAP : r.len;
    if (r.kind == REQ_COPY || r.kind == REQ_FILL) begin
      if (n > WORK_MAX) r.len = $urandom_range(0, 64);
    end else if (r.kind inside {REQ_RUN_FWD, REQ_FIND, REQ_RUN_BACK}) begin
      i = 0;
      while (i < n && i <= WORK_MAX && keeps_going(r, i)) i++;
      if (i > WORK_MAX) r.len = $urandom_range(0, 64);
    end
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(input dma_req_t r);
    int unsigned gap;
    gap = pick_gap(src_gaps_on);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.kind;
    s_axis_tdata <= {r.value, r.len, r.dst, r.src};
    do @(posedge clk); while (!s_axis_tready);
    owed_results.push_back(apply_request(r));
    @(negedge clk);
  endtask

  task automatic test_single_access();
    send_request(mk_req(REQ_READ, 32'd0, 32'd0, 32'd0, 8'h00));
    send_request(mk_req(REQ_READ, MEM_DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    send_request(mk_req(REQ_WRITE, 32'd10, 32'd0, 32'hFFFF_FFFF, 8'hA5));
    send_request(mk_req(REQ_READ, 32'd10, 32'd0, 32'd0, 8'h00));
    send_request(mk_req(REQ_WRITE, MEM_DEPTH, 32'd0, 32'd0, 8'h3C));
    send_request(mk_req(REQ_READ, MEM_DEPTH, 32'd0, 32'd0, 8'h00));
    send_request(mk_req(REQ_READ, 32'hFFFF_FFFF, 32'd0, 32'd5, 8'h00));
    send_request(mk_req(REQ_WRITE, MEM_DEPTH - 1, 32'd0, 32'd1, 8'hFF));
    send_request(mk_req(REQ_READ, MEM_DEPTH - 1, 32'd0, 32'd0, 8'h00));
    send_request(mk_req(REQ_UNKNOWN, 32'd0, 32'd0, 32'h8000_0001, 8'h00));
  endtask

  task automatic test_copy_fill();
    send_request(mk_req(REQ_FILL, 32'd0, 32'd100, 32'd0, 8'h11));
    send_request(mk_req(REQ_FILL, 32'd0, 32'd100, 32'd8, 8'h11));
    send_request(mk_req(REQ_FILL, 32'd0, 32'd104, 32'd4, 8'h22));
    // overlapping copies in both directions
    send_request(mk_req(REQ_COPY, 32'd100, 32'd102, 32'd6, 8'h00));
    send_request(mk_req(REQ_COPY, 32'd102, 32'd100, 32'd6, 8'h00));
    send_request(mk_req(REQ_COPY, 32'd100, 32'd300, 32'd0, 8'h00));
    send_request(mk_req(REQ_FILL, 32'd0, 32'hFFFF_FFFE, 32'd4, 8'h77));
    send_request(mk_req(REQ_COPY, MEM_DEPTH - 2, 32'd200, 32'd4, 8'h00));
    send_request(mk_req(REQ_COPY, 32'd0, MEM_DEPTH - 1, 32'd3, 8'h00));
  endtask

  task automatic test_search();
    send_request(mk_req(REQ_RUN_FWD, 32'd100, 32'd0, 32'd0, 8'h11));
    send_request(mk_req(REQ_RUN_FWD, 32'd100, 32'd0, 32'd16, 8'h11));
    send_request(mk_req(REQ_RUN_FWD, 32'd100, 32'd0, LEN_CAP + 1, 8'h11));
    send_request(mk_req(REQ_FIND, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'h22));
    send_request(mk_req(REQ_FIND, 32'd300, 32'd0, 32'd50, 8'h99));
    send_request(mk_req(REQ_FIND, MEM_DEPTH - 4, 32'd0, 32'd10, 8'hFF));
    send_request(mk_req(REQ_FIND, 32'd10, 32'd0, 32'd0, 8'hA5));
    send_request(mk_req(REQ_RUN_BACK, 32'd1, 32'd0, 32'd10, 8'h77));
    send_request(mk_req(REQ_RUN_BACK, MEM_DEPTH + 3, 32'd0, LEN_CAP, 8'hFF));
    send_request(mk_req(REQ_RUN_FWD, 32'hFFFF_FFFC, 32'd0, 32'd8, 8'hFF));
  endtask

  task automatic test_backpressure();
    src_gaps_on = 1'b0;
    sink_hold = 400;
    repeat (20) send_request(rand_request());
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random();
    for (int chunk = 0; chunk < 12; chunk++) begin
      src_gaps_on = $urandom_range(0, 3) != 0;
      sink_gaps_on = $urandom_range(0, 3) != 0;
      repeat (150) send_request(rand_request());
    end
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  // result side ready, with random stalls and one long hold on request
  initial begin
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(negedge clk);
      if (sink_hold != 0) begin
        wait_left = sink_hold;
        sink_hold = 0;
      end
      if (wait_left != 0) begin
        m_axis_tready <= 1'b0;
        wait_left--;
      end else begin
        m_axis_tready <= 1'b1;
        wait_left = pick_gap(sink_gaps_on);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $error("result_value: no result expected, got %h", m_axis_tdata);
        fail_count++;
      end else begin
        want_value = owed_results.pop_front();
        if (m_axis_tdata !== want_value) begin
          $error("result_value: expected %h, got %h", want_value, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  initial begin
    foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_single_access();
    test_copy_fill();
    test_search();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("** dma_copy_fill_search: PASSED **");
    end else begin
      $display("** dma_copy_fill_search: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
design/dcfs_pkg.sv
design/dma_copy_fill_search.sv
tb/dma_copy_fill_search_tb.sv
